[design/bts_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the bilinear texture scaler.
// No dependencies; all but the texel store refer to it by scoped names.
package bts_pkg;

   // Payload field widths, fixed by the channel formats
   localparam int FUNC_W     = 1;
   localparam int POS_W      = 10;
   localparam int TEXEL_W    = 8;
   localparam int OUT_W      = 11;
   localparam int SRC_REG_W  = 7;
   localparam int DST_REG_W  = 11;
   localparam int OFF_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 1'b1;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_X_OFFSET = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_Y_OFFSET = 3'd5;

   // Sample sequencer states
   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_COPY_RD,
      SEQ_COPY_WB,
      SEQ_MUL_PX,
      SEQ_MUL_PY,
      SEQ_RD_A,
      SEQ_RD_B,
      SEQ_RD_C,
      SEQ_RD_D,
      SEQ_MUL_D,
      SEQ_MUL_Q1,
      SEQ_MUL_Q2,
      SEQ_SUM,
      SEQ_DONE
   } seq_state_type;

   // Step ratio divider states
   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_X,
      DIV_Y
   } div_state_type;

   // Per-sample mode, derived from the size registers
   typedef struct packed {
      logic copy_mode;
      logic step_x;
      logic step_y;
   } sample_mode_type;

   // Top level to sequencer
   typedef struct packed {
      logic start;
      logic take;
   } seq_ctrl_type;

   // Sequencer to top level
   typedef struct packed {
      logic busy;
      logic res_valid;
   } seq_status_type;

endpackage

[design/bts_channel_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: sample/load requests, results, register writes.
// Depends on bts_pkg for field widths.

interface bts_req_if;
   logic                         valid;
   logic                         ready;
   logic [bts_pkg::FUNC_W-1:0]   func;
   logic [bts_pkg::POS_W-1:0]    pos_col;
   logic [bts_pkg::POS_W-1:0]    pos_row;
   logic [bts_pkg::TEXEL_W-1:0]  texel_value;

   modport source (output valid, func, pos_col, pos_row, texel_value, input ready);
   modport sink   (input valid, func, pos_col, pos_row, texel_value, output ready);
endinterface

interface bts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bts_pkg::OUT_W-1:0]    out_x;
   logic [bts_pkg::OUT_W-1:0]    out_y;
   logic [bts_pkg::TEXEL_W-1:0]  pixel_value;

   modport source (output valid, out_x, out_y, pixel_value, input ready);
   modport sink   (input valid, out_x, out_y, pixel_value, output ready);
endinterface

interface bts_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bts_pkg::CSR_IDX_W-1:0]   index;
   logic [bts_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/bts_texel_store.sv]
`timescale 1ns / 1ps
// Texture memory: one write port, one read port with registered read data.
// Standalone; no package needed.
module bts_texel_store #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

[design/bts_ratio_div.sv]
`timescale 1ns / 1ps
// Restoring divider for the x and y step ratios, one quotient bit per cycle.
// Depends on bts_pkg for the state type.
module bts_ratio_div #(
   parameter int FRAC_BITS = 16,
   parameter int SB        = 6,
   parameter int DDW       = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  logic [SB-1:0]         src_w_m1,
   input  logic [SB-1:0]         src_h_m1,
   input  logic [DDW-1:0]        dst_w,
   input  logic [DDW-1:0]        dst_h,
   output logic                  busy,
   output logic [SB+FRAC_BITS-1:0] x_ratio,
   output logic [SB+FRAC_BITS-1:0] y_ratio
);

   localparam int RW = SB + FRAC_BITS;
   localparam int CW = $clog2(RW);

   bts_pkg::div_state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [DDW-1:0] rem_ff, rem_in;
   logic [RW-1:0]  quo_ff, quo_in;
   logic [RW-1:0]  x_ratio_ff, x_ratio_in;
   logic [RW-1:0]  y_ratio_ff, y_ratio_in;

   logic [RW-1:0]  num;
   logic [DDW-1:0] den;
   logic [DDW:0]   shifted;
   logic [DDW:0]   trial;
   logic           geq;
   logic [RW-1:0]  quo_next;

   // Operands of the axis in progress
   always_comb begin
      if (state_ff == bts_pkg::DIV_Y) begin
         num = {src_h_m1, {FRAC_BITS{1'b0}}};
         den = dst_h;
      end else begin
         num = {src_w_m1, {FRAC_BITS{1'b0}}};
         den = dst_w;
      end
   end

   // One restoring step
   assign shifted  = {rem_ff, num[cnt_ff]};
   assign geq      = shifted >= {1'b0, den};
   assign trial    = shifted - {1'b0, den};
   assign quo_next = {quo_ff[RW-2:0], geq};

   // Next state and datapath
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      x_ratio_in = x_ratio_ff;
      y_ratio_in = y_ratio_ff;
      if (restart) begin
         state_in = bts_pkg::DIV_X;
         cnt_in   = CW'(RW - 1);
         rem_in   = '0;
      end else begin
         case (state_ff)
            bts_pkg::DIV_X, bts_pkg::DIV_Y: begin
               rem_in = geq ? trial[DDW-1:0] : shifted[DDW-1:0];
               quo_in = quo_next;
               cnt_in = cnt_ff - CW'(1);
               if (cnt_ff == '0) begin
                  cnt_in = CW'(RW - 1);
                  rem_in = '0;
                  if (state_ff == bts_pkg::DIV_X) begin
                     x_ratio_in = quo_next;
                     state_in   = bts_pkg::DIV_Y;
                  end else begin
                     y_ratio_in = quo_next;
                     state_in   = bts_pkg::DIV_IDLE;
                  end
               end
            end
            default: begin
               state_in = bts_pkg::DIV_IDLE;
            end
         endcase
      end
   end

   // State register; reset starts a fresh computation
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bts_pkg::DIV_X;
         cnt_ff     <= CW'(RW - 1);
         rem_ff     <= '0;
         x_ratio_ff <= '0;
         y_ratio_ff <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rem_ff     <= rem_in;
         x_ratio_ff <= x_ratio_in;
         y_ratio_ff <= y_ratio_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   assign busy    = state_ff != bts_pkg::DIV_IDLE;
   assign x_ratio = x_ratio_ff;
   assign y_ratio = y_ratio_ff;

endmodule

[design/bts_sample_seq.sv]
`timescale 1ns / 1ps
// Sample sequencer: one shared multiplier and accumulator walk through the
// position products, four reads and bilinear weights if scaled. Uses bts_pkg.
module bts_sample_seq #(
   parameter int FRAC_BITS = 16,
   parameter int SB        = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bts_pkg::seq_ctrl_type         ctrl,
   input  bts_pkg::sample_mode_type      mode,
   input  logic [bts_pkg::POS_W-1:0]     start_col,
   input  logic [bts_pkg::POS_W-1:0]     start_row,
   input  logic [bts_pkg::OUT_W-1:0]     start_x,
   input  logic [bts_pkg::OUT_W-1:0]     start_y,
   input  logic [SB+FRAC_BITS-1:0]       x_ratio,
   input  logic [SB+FRAC_BITS-1:0]       y_ratio,
   output logic [2*SB-1:0]               rd_addr,
   input  logic [bts_pkg::TEXEL_W-1:0]   rd_data,
   output bts_pkg::seq_status_type       status,
   output logic [bts_pkg::OUT_W-1:0]     res_x,
   output logic [bts_pkg::OUT_W-1:0]     res_y,
   output logic [bts_pkg::TEXEL_W-1:0]   res_pixel
);

   localparam int RW   = SB + FRAC_BITS;
   localparam int QW   = FRAC_BITS + bts_pkg::TEXEL_W;
   localparam int MA_W = (RW > QW) ? RW : QW;
   localparam int MB_W = (FRAC_BITS + 1 > bts_pkg::POS_W) ? FRAC_BITS + 1 : bts_pkg::POS_W;
   localparam int PW   = MA_W + MB_W;
   localparam int ACW  = FRAC_BITS + 9;

   bts_pkg::seq_state_type state_ff, state_in;

   logic [bts_pkg::POS_W-1:0]   col_ff, col_in;
   logic [bts_pkg::POS_W-1:0]   row_ff, row_in;
   logic [bts_pkg::OUT_W-1:0]   ox_ff, ox_in;
   logic [bts_pkg::OUT_W-1:0]   oy_ff, oy_in;
   logic [SB-1:0]               x_ff, x_in;
   logic [SB-1:0]               y_ff, y_in;
   logic [FRAC_BITS-1:0]        dx_ff, dx_in;
   logic [FRAC_BITS-1:0]        dy_ff, dy_in;
   logic [ACW-1:0]              acc_ff, acc_in;
   logic [ACW-1:0]              q1_ff, q1_in;
   logic [bts_pkg::TEXEL_W-1:0] pix_ff, pix_in;
   logic [PW-1:0]               prod_ff;

   logic [MA_W-1:0]     mul_a;
   logic [MB_W-1:0]     mul_b;
   logic [PW-1:0]       prod_in;
   logic [FRAC_BITS:0]  one_m_dx;
   logic [FRAC_BITS:0]  one_m_dy;
   logic [ACW-1:0]      prod_lo;
   logic [ACW-1:0]      prod_hi;
   logic [ACW-1:0]      sum;
   logic [8:0]          sum_int;
   logic [SB-1:0]       x_nb;
   logic [SB-1:0]       y_nb;

   // Weights and neighbor coordinates
   assign one_m_dx = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, dx_ff};
   assign one_m_dy = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, dy_ff};
   assign x_nb     = x_ff + SB'(mode.step_x);
   assign y_nb     = y_ff + SB'(mode.step_y);

   // Shared multiplier, product registered every cycle
   assign prod_in = PW'(mul_a) * PW'(mul_b);
   assign prod_lo = prod_ff[ACW-1:0];
   assign prod_hi = prod_ff[FRAC_BITS +: ACW];
   assign sum     = acc_ff + prod_hi;
   assign sum_int = sum[FRAC_BITS +: 9];

   // Sequencer: next state, operand select, register updates
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      acc_in   = acc_ff;
      q1_in    = q1_ff;
      pix_in   = pix_ff;
      mul_a    = '0;
      mul_b    = '0;
      rd_addr  = {col_ff[SB-1:0], row_ff[SB-1:0]};
      case (state_ff)
         bts_pkg::SEQ_IDLE: begin
            if (ctrl.start) begin
               col_in   = start_col;
               row_in   = start_row;
               ox_in    = start_x;
               oy_in    = start_y;
               state_in = mode.copy_mode ? bts_pkg::SEQ_COPY_RD : bts_pkg::SEQ_MUL_PX;
            end
         end
         bts_pkg::SEQ_COPY_RD: begin
            state_in = bts_pkg::SEQ_COPY_WB;
         end
         bts_pkg::SEQ_COPY_WB: begin
            pix_in   = rd_data;
            state_in = bts_pkg::SEQ_DONE;
         end
         bts_pkg::SEQ_MUL_PX: begin
            mul_a    = MA_W'(x_ratio);
            mul_b    = MB_W'(col_ff);
            state_in = bts_pkg::SEQ_MUL_PY;
         end
         bts_pkg::SEQ_MUL_PY: begin
            mul_a    = MA_W'(y_ratio);
            mul_b    = MB_W'(row_ff);
            x_in     = prod_ff[FRAC_BITS +: SB];
            dx_in    = prod_ff[FRAC_BITS-1:0];
            state_in = bts_pkg::SEQ_RD_A;
         end
         bts_pkg::SEQ_RD_A: begin
            y_in     = prod_ff[FRAC_BITS +: SB];
            dy_in    = prod_ff[FRAC_BITS-1:0];
            rd_addr  = {x_ff, prod_ff[FRAC_BITS +: SB]};
            state_in = bts_pkg::SEQ_RD_B;
         end
         bts_pkg::SEQ_RD_B: begin
            // top-left texel arrives
            rd_addr  = {x_nb, y_ff};
            mul_a    = MA_W'(rd_data);
            mul_b    = MB_W'(one_m_dx);
            state_in = bts_pkg::SEQ_RD_C;
         end
         bts_pkg::SEQ_RD_C: begin
            rd_addr  = {x_ff, y_nb};
            mul_a    = MA_W'(rd_data);
            mul_b    = MB_W'(dx_ff);
            acc_in   = prod_lo;
            state_in = bts_pkg::SEQ_RD_D;
         end
         bts_pkg::SEQ_RD_D: begin
            rd_addr  = {x_nb, y_nb};
            mul_a    = MA_W'(rd_data);
            mul_b    = MB_W'(one_m_dx);
            acc_in   = acc_ff + prod_lo;
            state_in = bts_pkg::SEQ_MUL_D;
         end
         bts_pkg::SEQ_MUL_D: begin
            // upper row blend complete
            mul_a    = MA_W'(rd_data);
            mul_b    = MB_W'(dx_ff);
            q1_in    = acc_ff;
            acc_in   = prod_lo;
            state_in = bts_pkg::SEQ_MUL_Q1;
         end
         bts_pkg::SEQ_MUL_Q1: begin
            mul_a    = MA_W'(q1_ff);
            mul_b    = MB_W'(one_m_dy);
            acc_in   = acc_ff + prod_lo;
            state_in = bts_pkg::SEQ_MUL_Q2;
         end
         bts_pkg::SEQ_MUL_Q2: begin
            // acc holds the lower row blend
            mul_a    = MA_W'(acc_ff);
            mul_b    = MB_W'(dy_ff);
            acc_in   = prod_hi;
            state_in = bts_pkg::SEQ_SUM;
         end
         bts_pkg::SEQ_SUM: begin
            pix_in   = (sum_int > 9'd255) ? 8'hFF : sum_int[7:0];
            state_in = bts_pkg::SEQ_DONE;
         end
         bts_pkg::SEQ_DONE: begin
            if (ctrl.take) begin
               state_in = bts_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = bts_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bts_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      row_ff  <= row_in;
      ox_ff   <= ox_in;
      oy_ff   <= oy_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      acc_ff  <= acc_in;
      q1_ff   <= q1_in;
      pix_ff  <= pix_in;
      prod_ff <= prod_in;
   end

   assign status.busy      = state_ff != bts_pkg::SEQ_IDLE;
   assign status.res_valid = state_ff == bts_pkg::SEQ_DONE;
   assign res_x            = ox_ff;
   assign res_y            = oy_ff;
   assign res_pixel        = pix_ff;

endmodule

[design/bilinear_texture_scaler.sv]
`timescale 1ns / 1ps
// Bilinear texture scaler top level: registers, texture store, ratio divider,
// sample sequencer and result register. Uses bts_pkg and bts_channel_if.
//
// Usage: load the texture with func=load beats on req_chan (texel at
// pos_col/pos_row), set sizes and offsets on csr_chan, then send func=sample
// beats naming output pixels. Each answered sample yields one beat on rsp_chan.
// A load leaves ready high. A sample in copy mode (equal source and destination
// sizes) reads one texel; a scaled sample steps through the position products,
// four texel reads and the weights in turn, set by the single shared multiplier
// and the one texture read port. Ready comes back once the result has moved to
// the output register; no request is taken while a sample is in the sequencer.
// Samples outside the object are dropped and give no result. After reset and
// after every register write the step ratio divider recomputes both ratios;
// req ready is low meanwhile. Register writes are always taken. A stalled
// result holds in the output register; a further sample finishing behind it
// waits in the sequencer. The texture store is not cleared by reset.
module bilinear_texture_scaler #(
   parameter int FRAC_BITS   = 16,
   parameter int MAX_SRC_DIM = 64,
   parameter int MAX_DST_DIM = 1024
) (
   input  logic          clock,
   input  logic          reset,
   bts_req_if.sink       req_chan,
   bts_rsp_if.source     rsp_chan,
   bts_csr_if.sink       csr_chan
);

   localparam int SB  = $clog2(MAX_SRC_DIM);
   localparam int SDW = $clog2(MAX_SRC_DIM + 1);
   localparam int DDW = $clog2(MAX_DST_DIM + 1);
   localparam int RW  = SB + FRAC_BITS;

   function automatic int clamp_dim(input int value, input int max_value);
      int result;
      result = value;
      if (value == 0) begin
         result = 1;
      end else if (value > max_value) begin
         result = max_value;
      end
      return result;
   endfunction

   // Configuration registers
   logic [bts_pkg::SRC_REG_W-1:0] src_w_ff, src_w_in;
   logic [bts_pkg::SRC_REG_W-1:0] src_h_ff, src_h_in;
   logic [bts_pkg::DST_REG_W-1:0] dst_w_ff, dst_w_in;
   logic [bts_pkg::DST_REG_W-1:0] dst_h_ff, dst_h_in;
   logic [bts_pkg::OFF_W-1:0]     off_x_ff, off_x_in;
   logic [bts_pkg::OFF_W-1:0]     off_y_ff, off_y_in;

   // Result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bts_pkg::OUT_W-1:0]     rsp_x_ff;
   logic [bts_pkg::OUT_W-1:0]     rsp_y_ff;
   logic [bts_pkg::TEXEL_W-1:0]   rsp_pix_ff;

   logic [SDW-1:0] src_w_eff, src_h_eff;
   logic [DDW-1:0] dst_w_eff, dst_h_eff;
   logic [SB-1:0]  src_w_m1, src_h_m1;
   logic           csr_write;
   logic           div_busy;
   logic [RW-1:0]  x_ratio, y_ratio;

   bts_pkg::sample_mode_type mode;
   bts_pkg::seq_ctrl_type    seq_ctrl;
   bts_pkg::seq_status_type  seq_status;

   logic                        req_accept;
   logic                        in_range;
   logic                        load_en;
   logic                        out_free;
   logic                        rsp_load;
   logic [bts_pkg::OUT_W-1:0]   start_x, start_y;
   logic [2*SB-1:0]             rd_addr;
   logic [bts_pkg::TEXEL_W-1:0] rd_data;
   logic [bts_pkg::OUT_W-1:0]   res_x, res_y;
   logic [bts_pkg::TEXEL_W-1:0] res_pixel;

   // Register writes
   assign csr_write      = csr_chan.valid && csr_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      dst_w_in = dst_w_ff;
      dst_h_in = dst_h_ff;
      off_x_in = off_x_ff;
      off_y_in = off_y_ff;
      if (csr_write) begin
         case (csr_chan.index)
            bts_pkg::CSR_SRC_WIDTH:     src_w_in = csr_chan.data[bts_pkg::SRC_REG_W-1:0];
            bts_pkg::CSR_SRC_HEIGHT:    src_h_in = csr_chan.data[bts_pkg::SRC_REG_W-1:0];
            bts_pkg::CSR_DST_WIDTH:     dst_w_in = csr_chan.data[bts_pkg::DST_REG_W-1:0];
            bts_pkg::CSR_DST_HEIGHT:    dst_h_in = csr_chan.data[bts_pkg::DST_REG_W-1:0];
            bts_pkg::CSR_DEST_X_OFFSET: off_x_in = csr_chan.data[bts_pkg::OFF_W-1:0];
            bts_pkg::CSR_DEST_Y_OFFSET: off_y_in = csr_chan.data[bts_pkg::OFF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= bts_pkg::SRC_REG_W'(64);
         src_h_ff <= bts_pkg::SRC_REG_W'(64);
         dst_w_ff <= bts_pkg::DST_REG_W'(64);
         dst_h_ff <= bts_pkg::DST_REG_W'(64);
         off_x_ff <= '0;
         off_y_ff <= '0;
      end else begin
         src_w_ff <= src_w_in;
         src_h_ff <= src_h_in;
         dst_w_ff <= dst_w_in;
         dst_h_ff <= dst_h_in;
         off_x_ff <= off_x_in;
         off_y_ff <= off_y_in;
      end
   end

   // Effective sizes and sample mode
   assign src_w_eff = SDW'(clamp_dim(int'(src_w_ff), MAX_SRC_DIM));
   assign src_h_eff = SDW'(clamp_dim(int'(src_h_ff), MAX_SRC_DIM));
   assign dst_w_eff = DDW'(clamp_dim(int'(dst_w_ff), MAX_DST_DIM));
   assign dst_h_eff = DDW'(clamp_dim(int'(dst_h_ff), MAX_DST_DIM));
   assign src_w_m1  = SB'(src_w_eff - SDW'(1));
   assign src_h_m1  = SB'(src_h_eff - SDW'(1));

   assign mode.copy_mode = (int'(src_w_eff) == int'(dst_w_eff))
                        && (int'(src_h_eff) == int'(dst_h_eff));
   assign mode.step_x    = src_w_eff != SDW'(1);
   assign mode.step_y    = src_h_eff != SDW'(1);

   // Request handling
   assign req_chan.ready = !div_busy && !seq_status.busy;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      if (mode.copy_mode) begin
         in_range = (int'(req_chan.pos_col) < int'(src_w_eff))
                 && (int'(req_chan.pos_row) < int'(src_h_eff));
         start_x  = bts_pkg::OUT_W'(off_x_ff) + bts_pkg::OUT_W'(req_chan.pos_col);
         start_y  = bts_pkg::OUT_W'(off_y_ff) + bts_pkg::OUT_W'(req_chan.pos_row);
      end else begin
         in_range = (int'(req_chan.pos_col) < int'(dst_w_eff))
                 && (int'(req_chan.pos_row) < int'(dst_h_eff));
         start_x  = bts_pkg::OUT_W'(req_chan.pos_col);
         start_y  = bts_pkg::OUT_W'(req_chan.pos_row);
      end
   end

   assign load_en = req_accept && (req_chan.func == bts_pkg::FUNC_LOAD)
                 && (int'(req_chan.pos_col) < MAX_SRC_DIM)
                 && (int'(req_chan.pos_row) < MAX_SRC_DIM);

   assign seq_ctrl.start = req_accept && (req_chan.func == bts_pkg::FUNC_SAMPLE) && in_range;
   assign seq_ctrl.take  = out_free;

   bts_texel_store #(
      .ADDR_W (2 * SB),
      .DATA_W (bts_pkg::TEXEL_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr ({req_chan.pos_col[SB-1:0], req_chan.pos_row[SB-1:0]}),
      .wr_data (req_chan.texel_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bts_ratio_div #(
      .FRAC_BITS (FRAC_BITS),
      .SB        (SB),
      .DDW       (DDW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_write),
      .src_w_m1 (src_w_m1),
      .src_h_m1 (src_h_m1),
      .dst_w    (dst_w_eff),
      .dst_h    (dst_h_eff),
      .busy     (div_busy),
      .x_ratio  (x_ratio),
      .y_ratio  (y_ratio)
   );

   bts_sample_seq #(
      .FRAC_BITS (FRAC_BITS),
      .SB        (SB)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (seq_ctrl),
      .mode      (mode),
      .start_col (req_chan.pos_col),
      .start_row (req_chan.pos_row),
      .start_x   (start_x),
      .start_y   (start_y),
      .x_ratio   (x_ratio),
      .y_ratio   (y_ratio),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .status    (seq_status),
      .res_x     (res_x),
      .res_y     (res_y),
      .res_pixel (res_pixel)
   );

   // Output register
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load = seq_status.res_valid && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_ff   <= res_x;
         rsp_y_ff   <= res_y;
         rsp_pix_ff <= res_pixel;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_x       = rsp_x_ff;
   assign rsp_chan.out_y       = rsp_y_ff;
   assign rsp_chan.pixel_value = rsp_pix_ff;

endmodule

[design/bts_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the bilinear texture scaler, bound to the top level.
// Depends on bts_pkg for the function codes.
module bts_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [bts_pkg::FUNC_W-1:0]  req_func,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        csr_valid,
   input logic                        csr_ready
);

   // Reset leaves no result and starts the ratio divider
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("request ready or result valid right after reset");

   // A register write restarts the ratios, so requests stall next cycle
   a_csr_stalls_req: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("request taken while step ratios recompute");

   // A texel load never produces a result beat
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == bts_pkg::FUNC_LOAD) && !rsp_valid
      |=> !rsp_valid)
      else $error("result beat appeared after a texel load");

   // Result beat holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result valid dropped while stalled");

endmodule

bind bilinear_texture_scaler bts_checker u_bts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_func  (req_chan.func),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .csr_valid (csr_chan.valid),
   .csr_ready (csr_chan.ready)
);

[tb/tb_bilinear_texture_scaler.sv]
`timescale 1ns / 1ps
// Self-checking testbench of bilinear_texture_scaler: a fixed-point pixel predictor
// inside a small scoreboard class, in-order checking of every result beat.
// Depends on bts_pkg, bts_channel_if and the design top level.
module tb_bilinear_texture_scaler;

   localparam int FRAC            = 16;
   localparam int TEX_DIM         = 64;
   localparam int DST_LIMIT       = 1024;
   localparam int TEX_CELLS       = TEX_DIM * TEX_DIM;
   localparam int CLK_HALF        = 4;
   localparam int RESET_CYCLES    = 9;
   localparam int SETTLE_CYCLES   = 16;
   localparam int TAIL_CYCLES     = 40;
   localparam int HOLD_CYCLES     = 300;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int MAX_REPORTS     = 10;
   localparam int POS_MAX         = 1023;

   // register indexes past the end of the map, which hold no register in the block
   localparam logic [bts_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [bts_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [bts_pkg::OUT_W-1:0]   x;
      logic [bts_pkg::OUT_W-1:0]   y;
      logic [bts_pkg::TEXEL_W-1:0] value;
   } pixel_beat_type;

   // Pixel predictor: own copy of registers, ratios and texture
   class pixel_board_type;
      bit [bts_pkg::SRC_REG_W-1:0] src_w, src_h;
      bit [bts_pkg::DST_REG_W-1:0] dst_w, dst_h;
      bit [bts_pkg::OFF_W-1:0]     off_x, off_y;
      longint unsigned             eff_sw, eff_sh, eff_dw, eff_dh;
      longint unsigned             x_ratio, y_ratio;
      bit [bts_pkg::TEXEL_W-1:0]   texels [TEX_CELLS];
      bit                          written [TEX_CELLS];
      pixel_beat_type              pending_pixels [$];
      int                          failures;

      function new();
         src_w = 64;
         src_h = 64;
         dst_w = 64;
         dst_h = 64;
         off_x = 0;
         off_y = 0;
         failures = 0;
         foreach (written[i]) begin
            written[i] = 1'b0;
            texels[i] = '0;
         end
         refresh_ratios();
      endfunction

      // zero acts as one, oversize clamps to the limit
      function longint unsigned clamp_size(longint unsigned v, longint unsigned vmax);
         if (v == 0) return 1;
         if (v > vmax) return vmax;
         return v;
      endfunction

      function void refresh_ratios();
         eff_sw = clamp_size(src_w, TEX_DIM);
         eff_sh = clamp_size(src_h, TEX_DIM);
         eff_dw = clamp_size(dst_w, DST_LIMIT);
         eff_dh = clamp_size(dst_h, DST_LIMIT);
         x_ratio = ((eff_sw - 1) << FRAC) / eff_dw;
         y_ratio = ((eff_sh - 1) << FRAC) / eff_dh;
      endfunction

      function void write_reg(bit [bts_pkg::CSR_IDX_W-1:0] idx,
                              bit [bts_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            bts_pkg::CSR_SRC_WIDTH:     src_w = data[bts_pkg::SRC_REG_W-1:0];
            bts_pkg::CSR_SRC_HEIGHT:    src_h = data[bts_pkg::SRC_REG_W-1:0];
            bts_pkg::CSR_DST_WIDTH:     dst_w = data[bts_pkg::DST_REG_W-1:0];
            bts_pkg::CSR_DST_HEIGHT:    dst_h = data[bts_pkg::DST_REG_W-1:0];
            bts_pkg::CSR_DEST_X_OFFSET: off_x = data[bts_pkg::OFF_W-1:0];
            bts_pkg::CSR_DEST_Y_OFFSET: off_y = data[bts_pkg::OFF_W-1:0];
            default: return;
         endcase
         refresh_ratios();
      endfunction

      function bit is_copy();
         return (eff_sw == eff_dw) && (eff_sh == eff_dh);
      endfunction

      function longint unsigned texel_at(longint unsigned c, longint unsigned r);
         if (c >= TEX_DIM || r >= TEX_DIM) return 0;
         return texels[c * TEX_DIM + r];
      endfunction

      function longint unsigned fx_mul(longint unsigned a, longint unsigned b);
         return (a * b) >> FRAC;
      endfunction

      // Source position of an output pixel; returns 0 when the sample is dropped
      function bit map_sample(input bit [bts_pkg::POS_W-1:0] col, row, output bit copy,
                              output longint unsigned x, y, dx, dy, sx, sy);
         longint unsigned px, py;
         copy = is_copy();
         x = 0;
         y = 0;
         dx = 0;
         dy = 0;
         sx = 0;
         sy = 0;
         if (copy) begin
            x = col;
            y = row;
            return (col < eff_sw) && (row < eff_sh);
         end
         if (col >= eff_dw || row >= eff_dh) return 0;
         px = x_ratio * col;
         py = y_ratio * row;
         x = px >> FRAC;
         y = py >> FRAC;
         dx = px & ((64'd1 << FRAC) - 1);
         dy = py & ((64'd1 << FRAC) - 1);
         sx = (eff_sw == 1) ? 0 : 1;
         sy = (eff_sh == 1) ? 0 : 1;
         return 1'b1;
      endfunction

      // Store entries a sample will read, so the driver can load them first
      function void texels_read(input bit [bts_pkg::POS_W-1:0] col, row,
                                output int unsigned taps [4], output int ntaps);
         bit copy;
         longint unsigned x, y, dx, dy, sx, sy;
         ntaps = 0;
         foreach (taps[i]) taps[i] = 0;
         if (!map_sample(col, row, copy, x, y, dx, dy, sx, sy)) return;
         taps[0] = int'(x * TEX_DIM + y);
         ntaps = 1;
         if (copy) return;
         taps[1] = int'((x + sx) * TEX_DIM + y);
         taps[2] = int'(x * TEX_DIM + (y + sy));
         taps[3] = int'((x + sx) * TEX_DIM + (y + sy));
         ntaps = 4;
      endfunction

      // Accepted request beat: update the texture or queue the predicted pixel
      function void take_request(bit [bts_pkg::FUNC_W-1:0] func,
                                 bit [bts_pkg::POS_W-1:0] col, row,
                                 bit [bts_pkg::TEXEL_W-1:0] value);
         pixel_beat_type want;
         bit copy;
         longint unsigned x, y, dx, dy, sx, sy, one, q1, q2, acc, v;
         if (func == bts_pkg::FUNC_LOAD) begin
            if (col < TEX_DIM && row < TEX_DIM) begin
               texels[col * TEX_DIM + row] = value;
               written[col * TEX_DIM + row] = 1'b1;
            end
            return;
         end
         if (!map_sample(col, row, copy, x, y, dx, dy, sx, sy)) return;
         if (copy) begin
            acc = longint'(off_x) + col;
            want.x = acc[bts_pkg::OUT_W-1:0];
            acc = longint'(off_y) + row;
            want.y = acc[bts_pkg::OUT_W-1:0];
            v = texel_at(col, row);
         end else begin
            one = 64'd1 << FRAC;
            q1 = fx_mul(texel_at(x, y) << FRAC, one - dx)
               + fx_mul(texel_at(x + sx, y) << FRAC, dx);
            q2 = fx_mul(texel_at(x, y + sy) << FRAC, one - dx)
               + fx_mul(texel_at(x + sx, y + sy) << FRAC, dx);
            acc = fx_mul(q1, one - dy) + fx_mul(q2, dy);
            v = acc >> FRAC;
            if (v > 255) v = 255;
            want.x = bts_pkg::OUT_W'(col);
            want.y = bts_pkg::OUT_W'(row);
         end
         want.value = v[bts_pkg::TEXEL_W-1:0];
         pending_pixels.push_back(want);
      endfunction

      // Accepted result beat against the oldest prediction
      function void check_pixel(pixel_beat_type got);
         pixel_beat_type want;
         if (pending_pixels.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected pixel x=%0d y=%0d value=%0d", got.x, got.y, got.value);
            return;
         end
         want = pending_pixels.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("pixel mismatch: expected x=%0d y=%0d value=%0d, got x=%0d y=%0d value=%0d",
                        want.x, want.y, want.value, got.x, got.y, got.value);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   bts_req_if req_bus ();
   bts_rsp_if rsp_bus ();
   bts_csr_if csr_bus ();

   pixel_board_type board;

   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   hold_left = 0;
   logic hold_kick = 1'b0;

   bilinear_texture_scaler #(
      .FRAC_BITS   (FRAC),
      .MAX_SRC_DIM (TEX_DIM),
      .MAX_DST_DIM (DST_LIMIT)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #CLK_HALF clock = ~clock;

   // Long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_kick)
         hold_left <= HOLD_CYCLES;
      else if (hold_left > 0)
         hold_left <= hold_left - 1;
   end

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_bus.ready = (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready)
         board.check_pixel({rsp_bus.out_x, rsp_bus.out_y, rsp_bus.pixel_value});
   end

   // One request beat; returns at the falling edge after it is taken, valid still high
   task automatic send_item(input logic [bts_pkg::FUNC_W-1:0] func,
                            input int unsigned col, row, value);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.func        = func;
      req_bus.pos_col     = col[bts_pkg::POS_W-1:0];
      req_bus.pos_row     = row[bts_pkg::POS_W-1:0];
      req_bus.texel_value = value[bts_pkg::TEXEL_W-1:0];
      req_bus.valid       = 1'b1;
      forever begin
         @(posedge clock);
         if (req_bus.ready) break;
      end
      board.take_request(func, req_bus.pos_col, req_bus.pos_row, req_bus.texel_value);
      @(negedge clock);
   endtask

   // Sample beat, preceded by loads of any texel it reads that was never written
   task automatic send_sample(input int unsigned col, row);
      int unsigned taps [4];
      int ntaps;
      board.texels_read(col[bts_pkg::POS_W-1:0], row[bts_pkg::POS_W-1:0], taps, ntaps);
      for (int i = 0; i < ntaps; i++)
         if (!board.written[taps[i]])
            send_item(bts_pkg::FUNC_LOAD, taps[i] / TEX_DIM, taps[i] % TEX_DIM,
                      $urandom_range(255));
      send_item(bts_pkg::FUNC_SAMPLE, col, row, $urandom_range(255));
   endtask

   task automatic write_reg(input logic [bts_pkg::CSR_IDX_W-1:0] idx, input int unsigned data);
      csr_bus.index = idx;
      csr_bus.data  = data[bts_pkg::CSR_DATA_W-1:0];
      csr_bus.valid = 1'b1;
      forever begin
         @(posedge clock);
         if (csr_bus.ready) break;
      end
      board.write_reg(idx, csr_bus.data);
      @(negedge clock);
   endtask

   task automatic set_config(input int unsigned sw, sh, dw, dh, ox, oy);
      write_reg(bts_pkg::CSR_SRC_WIDTH, sw);
      write_reg(bts_pkg::CSR_SRC_HEIGHT, sh);
      write_reg(bts_pkg::CSR_DST_WIDTH, dw);
      write_reg(bts_pkg::CSR_DST_HEIGHT, dh);
      write_reg(bts_pkg::CSR_DEST_X_OFFSET, ox);
      write_reg(bts_pkg::CSR_DEST_Y_OFFSET, oy);
      csr_bus.valid = 1'b0;
   endtask

   // Sender stops until every predicted pixel is out and the block has gone quiet
   task automatic drain();
      req_bus.valid = 1'b0;
      while (board.pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic int unsigned pick_src();
      case ($urandom_range(9))
         0: return 0;
         1: return 1;
         2: return 64;
         3: return $urandom_range(127, 65);
         4: return $urandom_range(64, 2);
         default: return $urandom_range(12, 2);
      endcase
   endfunction

   function automatic int unsigned pick_dst();
      case ($urandom_range(9))
         0: return 0;
         1: return 1;
         2: return 1024;
         3: return $urandom_range(2047, 1025);
         4: return $urandom_range(1024, 2);
         default: return $urandom_range(40, 2);
      endcase
   endfunction

   function automatic int unsigned pick_offset();
      case ($urandom_range(5))
         0: return 0;
         1: return 1023;
         default: return $urandom_range(1023);
      endcase
   endfunction

   task automatic random_config();
      int unsigned sw, sh, dw, dh;
      sw = pick_src();
      sh = pick_src();
      if ($urandom_range(4) == 0) begin
         dw = sw;
         dh = sh;
      end else begin
         dw = pick_dst();
         dh = pick_dst();
      end
      if ($urandom_range(3) == 0)
         write_reg($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom_range(2047));
      set_config(sw, sh, dw, dh, pick_offset(), pick_offset());
   endtask

   // Mostly in-object samples on loaded texels, with loads and strays mixed in
   task automatic run_random(input int n);
      int unsigned w, h, col, row;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 25) begin
            if ($urandom_range(9) == 0) begin
               col = $urandom_range(POS_MAX);
               row = $urandom_range(POS_MAX);
            end else begin
               col = $urandom_range(TEX_DIM - 1);
               row = $urandom_range(TEX_DIM - 1);
            end
            send_item(bts_pkg::FUNC_LOAD, col, row, $urandom_range(255));
         end else begin
            w = int'(board.is_copy() ? board.eff_sw : board.eff_dw);
            h = int'(board.is_copy() ? board.eff_sh : board.eff_dh);
            col = $urandom_range(w - 1);
            row = $urandom_range(h - 1);
            case ($urandom_range(19))
               0: begin
                  col = $urandom_range(POS_MAX);
                  row = $urandom_range(POS_MAX);
               end
               1: col = (w > POS_MAX) ? POS_MAX : w;
               2: row = (h > POS_MAX) ? POS_MAX : h;
               default: ;
            endcase
            send_sample(col, row);
         end
      end
   endtask

   initial begin
      board = new();
      req_bus.valid       = 1'b0;
      req_bus.func        = bts_pkg::FUNC_LOAD;
      req_bus.pos_col     = '0;
      req_bus.pos_row     = '0;
      req_bus.texel_value = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = bts_pkg::CSR_SRC_WIDTH;
      csr_bus.data        = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: copy mode 64x64, corner texels, two of them at the value extremes
      send_item(bts_pkg::FUNC_LOAD, 0, 0, 0);
      send_item(bts_pkg::FUNC_LOAD, 63, 63, 255);
      send_item(bts_pkg::FUNC_LOAD, 63, 0, 128);
      send_item(bts_pkg::FUNC_LOAD, 0, 63, 1);
      // loads outside the store are ignored
      send_item(bts_pkg::FUNC_LOAD, 64, 0, 77);
      send_item(bts_pkg::FUNC_LOAD, 1023, 1023, 200);
      send_sample(0, 0);
      send_sample(63, 63);
      send_sample(63, 0);
      send_sample(0, 63);
      // requests outside the object give nothing
      send_sample(64, 0);
      send_sample(0, 64);
      send_sample(1023, 1023);
      drain();

      // Copy mode at the largest offsets; unmapped indexes must be ignored
      write_reg(CSR_SPARE_LO, 2047);
      write_reg(CSR_SPARE_HI, 0);
      set_config(64, 64, 64, 64, 1023, 1023);
      send_sample(63, 63);
      send_sample(0, 0);
      drain();

      // Largest enlargement: 2x2 texture over the full destination
      set_config(2, 2, 1024, 1024, 0, 0);
      send_item(bts_pkg::FUNC_LOAD, 1, 1, 255);
      send_sample(0, 0);
      send_sample(1023, 1023);
      send_sample(512, 511);
      drain();

      // Single-texel column, oversize and zero sizes that clamp
      set_config(1, 127, 0, 2047, 5, 5);
      send_sample(0, 1023);
      send_sample(1, 0);
      send_sample(0, 500);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         random_config();
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 72; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 72; end
            default: begin send_idle_pct = 21; rsp_stall_pct = 21; end
         endcase
         // receiver holds off while the sender keeps pushing, so the input backs up
         if (p == 4) begin
            hold_kick = 1'b1;
            @(negedge clock);
            hold_kick = 1'b0;
         end
         run_random(ITEMS_PER_PHASE);
         drain();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (board.failures == 0 && board.pending_pixels.size() == 0)
         $display("tb_bilinear_texture_scaler passed");
      else
         $display("tb_bilinear_texture_scaler failed");
      $finish;
   end

   // Watchdog
   initial begin
      #8_000_000;
      $display("tb_bilinear_texture_scaler failed");
      $finish;
   end

endmodule
